FILE: rtl/irctok_pkg.sv
// ----------------------------------------------------------------------------
// IRC tokenizer package
// Character codes, result codes and the result and queue word types shared
// by the tokenizer's front end, queue and back end.
// ----------------------------------------------------------------------------
package irctok_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] ROLE_PREFIX  = 2'd0;
   localparam logic [1:0] ROLE_COMMAND = 2'd1;
   localparam logic [1:0] ROLE_MIDDLE  = 2'd2;
   localparam logic [1:0] ROLE_TRAIL   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] role;
      logic [3:0] index;
      logic [7:0] char_out;
      logic       first;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type first_res;
      result_type second_res;
   } entry_type;

   function automatic result_type make_result(
      input logic [1:0] kind,
      input logic [1:0] role,
      input logic [3:0] count_low,
      input logic [7:0] char_out,
      input logic       first
   );
      result_type res;
      res.kind     = kind;
      res.role     = role;
      res.index    = 4'd0;
      if (kind != KIND_END && (role == ROLE_MIDDLE || role == ROLE_TRAIL))
         res.index = count_low;
      res.char_out = char_out;
      res.first    = first;
      return res;
   endfunction

endpackage

FILE: rtl/irc_line_tokenizer.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer
// Splits a byte stream into IRC lines and tags prefix, command, middle and
// trailing parameter bytes, empty fields and message ends.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on the req channel and gives one result
// per clock on the rsp channel while rsp_stall is low. A byte that causes two
// results (a field byte last in its buffer, or a line close after an open
// prefix or trailing colon) uses the single result port twice; a four-word
// queue between the byte classifier and the result unpacker absorbs these, so
// input stalls only when such bytes come in a long run or while rsp_stall
// holds the output. Results reach the rsp ports through the queue and the
// registered result port. Bytes that cause no result (CR LF second half, a
// terminator at buffer start and, unless last in the buffer, a space closing
// a nonempty field or a prefix or trailing colon) stall only on a full queue.
// ----------------------------------------------------------------------------
module irc_line_tokenizer #(
   parameter int MAX_PARAM_INDEX = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [1:0] rsp_field_role,
   output logic [3:0] rsp_param_index,
   output logic [7:0] rsp_char_out,
   output logic       rsp_first_of_field,
   output logic       rsp_last_result
);

   logic                  push;
   logic                  full;
   logic                  pop;
   logic                  empty;
   irctok_pkg::entry_type push_entry;
   irctok_pkg::entry_type head;

   irctok_front #(
      .MAX_PARAM_INDEX (MAX_PARAM_INDEX)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .full               (full),
      .push               (push),
      .push_entry         (push_entry)
   );

   irctok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   irctok_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_field_role     (rsp_field_role),
      .rsp_param_index    (rsp_param_index),
      .rsp_char_out       (rsp_char_out),
      .rsp_first_of_field (rsp_first_of_field),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

FILE: rtl/irctok_front.sv
// ----------------------------------------------------------------------------
// IRC tokenizer front end
// Accepts one byte per cycle while the queue is not full, tracks line and field
// state, and packs the results a byte causes, at most two, into a queue word.
// ----------------------------------------------------------------------------
module irctok_front #(
   parameter int MAX_PARAM_INDEX = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_in_buffer,
   input  logic                  full,
   output logic                  push,
   output irctok_pkg::entry_type push_entry
);

   localparam int CountWidth =
      ($clog2(MAX_PARAM_INDEX + 1) > 4) ? $clog2(MAX_PARAM_INDEX + 1) : 4;

   typedef enum logic [2:0] {
      PH_START,
      PH_PREFIX,
      PH_COMMAND,
      PH_MIDDLE,
      PH_TRAIL
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    at_start_ff, at_start_in;
   logic                    prev_cr_ff, prev_cr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    started_ff, started_in;

   logic                    accept;
   logic                    is_cr, is_lf, is_term, is_space, is_colon;
   logic                    tc_hit;
   irctok_pkg::result_type  tc_res;
   phase_type               tc_phase;
   logic [CountWidth-1:0]   tc_count;
   logic                    tc_started;
   phase_type               mid_phase;
   logic [CountWidth-1:0]   mid_count;
   logic                    mid_started;
   logic                    do_end;
   logic                    empty_hit;
   irctok_pkg::result_type  empty_res;
   irctok_pkg::result_type  end_res;
   logic                    have_a;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_comb begin
      is_cr    = (req_data_byte == irctok_pkg::CHAR_CR);
      is_lf    = (req_data_byte == irctok_pkg::CHAR_LF);
      is_term  = is_cr || is_lf;
      is_space = (req_data_byte == irctok_pkg::CHAR_SPACE);
      is_colon = (req_data_byte == irctok_pkg::CHAR_COLON);

      tc_hit     = 1'b0;
      tc_res     = '0;
      tc_phase   = phase_ff;
      tc_count   = count_ff;
      tc_started = started_ff;
      unique case (phase_ff)
         PH_PREFIX: begin
            if (is_space) begin
               tc_hit     = !started_ff;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_EMPTY,
                  irctok_pkg::ROLE_PREFIX, count_ff[3:0], 8'd0, 1'b0);
               tc_phase   = PH_COMMAND;
               tc_started = 1'b0;
            end else begin
               tc_hit     = 1'b1;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_BYTE,
                  irctok_pkg::ROLE_PREFIX, count_ff[3:0], req_data_byte, !started_ff);
               tc_started = 1'b1;
            end
         end
         PH_COMMAND: begin
            if (is_space) begin
               tc_hit     = !started_ff;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_EMPTY,
                  irctok_pkg::ROLE_COMMAND, count_ff[3:0], 8'd0, 1'b0);
               tc_phase   = PH_MIDDLE;
               tc_started = 1'b0;
            end else begin
               tc_hit     = 1'b1;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_BYTE,
                  irctok_pkg::ROLE_COMMAND, count_ff[3:0], req_data_byte, !started_ff);
               tc_started = 1'b1;
            end
         end
         PH_MIDDLE: begin
            if (is_space) begin
               tc_hit     = !started_ff;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_EMPTY,
                  irctok_pkg::ROLE_MIDDLE, count_ff[3:0], 8'd0, 1'b0);
               if (count_ff < CountWidth'(MAX_PARAM_INDEX))
                  tc_count = count_ff + 1'b1;
               tc_started = 1'b0;
            end else if (is_colon && !started_ff) begin
               tc_phase   = PH_TRAIL;
            end else begin
               tc_hit     = 1'b1;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_BYTE,
                  irctok_pkg::ROLE_MIDDLE, count_ff[3:0], req_data_byte, !started_ff);
               tc_started = 1'b1;
            end
         end
         PH_TRAIL: begin
            tc_hit     = 1'b1;
            tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_BYTE,
               irctok_pkg::ROLE_TRAIL, count_ff[3:0], req_data_byte, !started_ff);
            tc_started = 1'b1;
         end
         default: begin
            tc_count   = '0;
            tc_started = 1'b0;
            if (is_colon) begin
               tc_phase = PH_PREFIX;
            end else if (is_space) begin
               tc_hit   = 1'b1;
               tc_res   = irctok_pkg::make_result(irctok_pkg::KIND_EMPTY,
                  irctok_pkg::ROLE_COMMAND, 4'd0, 8'd0, 1'b0);
               tc_phase = PH_MIDDLE;
            end else begin
               tc_hit     = 1'b1;
               tc_res     = irctok_pkg::make_result(irctok_pkg::KIND_BYTE,
                  irctok_pkg::ROLE_COMMAND, 4'd0, req_data_byte, 1'b1);
               tc_phase   = PH_COMMAND;
               tc_started = 1'b1;
            end
         end
      endcase

      // line close sees the state after the byte's own field work
      mid_phase   = is_term ? phase_ff   : tc_phase;
      mid_count   = is_term ? count_ff   : tc_count;
      mid_started = is_term ? started_ff : tc_started;

      do_end = is_term ? (!at_start_ff && !(prev_cr_ff && is_lf)) : req_last_in_buffer;

      empty_hit = do_end && !mid_started &&
                  (mid_phase == PH_PREFIX || mid_phase == PH_TRAIL);
      empty_res = irctok_pkg::make_result(irctok_pkg::KIND_EMPTY,
         (mid_phase == PH_PREFIX) ? irctok_pkg::ROLE_PREFIX : irctok_pkg::ROLE_TRAIL,
         mid_count[3:0], 8'd0, 1'b0);
      end_res   = irctok_pkg::make_result(irctok_pkg::KIND_END,
         irctok_pkg::ROLE_PREFIX, 4'd0, 8'd0, 1'b0);

      // pack the first two of: field result, empty marker, end of message
      have_a = !is_term && tc_hit;
      push_entry.two = (have_a && (empty_hit || do_end)) || (empty_hit && do_end);
      priority if (have_a) begin
         push_entry.first_res  = tc_res;
         push_entry.second_res = empty_hit ? empty_res : end_res;
      end else if (empty_hit) begin
         push_entry.first_res  = empty_res;
         push_entry.second_res = end_res;
      end else begin
         push_entry.first_res  = end_res;
         push_entry.second_res = end_res;
      end
      push = accept && (have_a || empty_hit || do_end);

      phase_in    = phase_ff;
      at_start_in = at_start_ff;
      prev_cr_in  = prev_cr_ff;
      count_in    = count_ff;
      started_in  = started_ff;
      if (accept) begin
         at_start_in = req_last_in_buffer;
         prev_cr_in  = !req_last_in_buffer && is_term && do_end && is_cr;
         phase_in    = do_end ? PH_START : mid_phase;
         count_in    = do_end ? '0 : mid_count;
         started_in  = do_end ? 1'b0 : mid_started;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         at_start_ff <= 1'b1;
         prev_cr_ff  <= 1'b0;
         count_ff    <= '0;
         started_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         at_start_ff <= at_start_in;
         prev_cr_ff  <= prev_cr_in;
         count_ff    <= count_in;
         started_ff  <= started_in;
      end
   end

endmodule

FILE: rtl/irctok_queue.sv
// ----------------------------------------------------------------------------
// IRC tokenizer queue
// Small register queue of result words between the front and back ends.
// ----------------------------------------------------------------------------
module irctok_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  irctok_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output irctok_pkg::entry_type head
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   irctok_pkg::entry_type   mem_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == CountWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_entry;
   end

`ifndef NO_ASSERTIONS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/irctok_back.sv
// ----------------------------------------------------------------------------
// IRC tokenizer back end
// Unpacks queue words into single results and drives the registered result
// channel, holding a second result until the first is taken.
// ----------------------------------------------------------------------------
module irctok_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  irctok_pkg::entry_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [1:0]            rsp_field_role,
   output logic [3:0]            rsp_param_index,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_first_of_field,
   output logic                  rsp_last_result
);

   logic                    out_valid_ff, out_valid_in;
   irctok_pkg::result_type  out_ff, out_in;
   logic                    out_last_ff, out_last_in;
   logic                    sec_valid_ff, sec_valid_in;
   irctok_pkg::result_type  sec_ff, sec_in;
   logic                    load;

   always_comb begin
      load         = !out_valid_ff || !rsp_stall;
      pop          = load && !sec_valid_ff && !empty;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      sec_valid_in = sec_valid_ff;
      sec_in       = sec_ff;
      if (load) begin
         priority if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = sec_ff;
            out_last_in  = 1'b1;
            sec_valid_in = 1'b0;
         end else if (!empty) begin
            out_valid_in = 1'b1;
            out_in       = head.first_res;
            out_last_in  = !head.two;
            sec_valid_in = head.two;
            sec_in       = head.second_res;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      sec_ff      <= sec_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_ff.kind;
   assign rsp_field_role     = out_ff.role;
   assign rsp_param_index    = out_ff.index;
   assign rsp_char_out       = out_ff.char_out;
   assign rsp_first_of_field = out_ff.first;
   assign rsp_last_result    = out_last_ff;

`ifndef NO_ASSERTIONS
   a_second_behind_first: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> out_valid_ff)
      else $error("second result pending without a first on the port");

   a_no_pop_while_second: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> !pop)
      else $error("queue popped while a second result is pending");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == irctok_pkg::KIND_END) |-> out_last_ff)
      else $error("end of message not marked as the final result");
`endif

endmodule
